@@ hw/rtl/topic_filter_match_macros.svh @@
// Assertion helpers used by the checker file tfm_checker.sv
`ifndef TOPIC_FILTER_MATCH_MACROS_SVH
`define TOPIC_FILTER_MATCH_MACROS_SVH

// Check a property on every clock edge outside reset
`define TFM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition
`define TFM_ASSERT_HOLD(name, cond, sig, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

@@ hw/rtl/tfm_pkg.sv @@
package tfm_pkg;

    // Filter storage and register port geometry
    localparam int MAX_FILTER_BYTES_DEF = 32;
    localparam int FILTER_WORDS         = 4;
    localparam int DATA_W               = 64;
    localparam int FILTER_BITS          = FILTER_WORDS * DATA_W;
    localparam int LEN_W                = 6;
    localparam int ADDR_W               = 6;

    // Bytes with a special meaning in a filter
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    // Register reset values
    localparam logic [DATA_W-1:0] FILTER_0_RESET = 64'd35;
    localparam logic [LEN_W-1:0]  LENGTH_RESET   = 6'd1;

    typedef enum logic [2:0] {
        REG_FILTER_0 = 3'd0,
        REG_FILTER_1 = 3'd1,
        REG_FILTER_2 = 3'd2,
        REG_FILTER_3 = 3'd3,
        REG_LENGTH   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_MATCHING = 2'd0,
        ST_FAILED   = 2'd1,
        ST_HASH     = 2'd2
    } status_t;

    // Filter as seen by the matcher
    typedef struct packed {
        logic [FILTER_BITS-1:0] bytes;
        logic [LEN_W-1:0]       length;
    } filter_t;

endpackage

@@ hw/rtl/tfm_cfg_regs.sv @@
module tfm_cfg_regs
    import tfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output filter_t           filter
);

    logic [DATA_W-1:0] word_reg [FILTER_WORDS];
    logic [LEN_W-1:0]  length_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg[0] <= FILTER_0_RESET;
            word_reg[1] <= '0;
            word_reg[2] <= '0;
            word_reg[3] <= '0;
            length_reg  <= LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FILTER_0: word_reg[0] <= pwdata;
                REG_FILTER_1: word_reg[1] <= pwdata;
                REG_FILTER_2: word_reg[2] <= pwdata;
                REG_FILTER_3: word_reg[3] <= pwdata;
                REG_LENGTH:   length_reg  <= pwdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            REG_FILTER_0: prdata = word_reg[0];
            REG_FILTER_1: prdata = word_reg[1];
            REG_FILTER_2: prdata = word_reg[2];
            REG_FILTER_3: prdata = word_reg[3];
            REG_LENGTH:   prdata = {{(DATA_W-LEN_W){1'b0}}, length_reg};
            default:      prdata = '0;
        endcase
    end

    assign filter.bytes  = {word_reg[3], word_reg[2], word_reg[1], word_reg[0]};
    assign filter.length = length_reg;

endmodule

@@ hw/rtl/tfm_match.sv @@
module tfm_match
    import tfm_pkg::*;
#(
    parameter int MAX_FILTER_BYTES = MAX_FILTER_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  filter_t    filter,
    input  logic [7:0] topic_char,
    input  logic       last_char,
    input  logic       topic_valid,
    output logic       topic_ready,
    output logic       matched,
    output logic       result_valid,
    input  logic       result_ready
);

    localparam int              IDX_W   = $clog2(MAX_FILTER_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FILTER_BYTES);
    localparam logic [LEN_W-1:0] ONE     = LEN_W'(1);

    typedef logic [7:0] fbytes_t [MAX_FILTER_BYTES];

    // Byte p of the filter equals ch and lies inside the used length
    function automatic logic byte_is(fbytes_t b, logic [LEN_W-1:0] n,
                                     logic [LEN_W-1:0] p, logic [7:0] ch);
        byte_is = (p < n) && (b[p[IDX_W-1:0]] == ch);
    endfunction

    // The filter level starting at p is exactly the byte ch
    function automatic logic level_is(fbytes_t b, logic [LEN_W-1:0] n,
                                      logic [LEN_W-1:0] p, logic [7:0] ch);
        logic start;
        logic stop;
        start    = (p == '0) || byte_is(b, n, p - ONE, CHAR_SLASH);
        stop     = ((p + ONE) >= n) || byte_is(b, n, p + ONE, CHAR_SLASH);
        level_is = start && byte_is(b, n, p, ch) && stop;
    endfunction

    fbytes_t          fb;
    logic [LEN_W-1:0] len_used;

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_last_reg;
    logic             proc;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             plus_reg, plus_next;
    status_t          status_reg, status_next;
    logic             out_valid_reg;
    logic             matched_reg;

    logic             hash_here;
    logic             plus_here;
    logic             plus_now;
    logic [LEN_W-1:0] pos_cmp;
    logic             verdict;

    // Unpack the filter and clamp its length
    always_comb
    begin
        for (int i = 0; i < MAX_FILTER_BYTES; i++)
        begin
            fb[i] = filter.bytes[8*i +: 8];
        end
    end

    assign len_used = (filter.length > MAX_LEN) ? MAX_LEN : filter.length;

    // Advance when the result side can take what this word produces
    assign proc        = in_valid_reg && (!in_last_reg || !out_valid_reg || result_ready);
    assign topic_ready = !in_valid_reg || proc;

    // Wildcard levels at the current filter position
    assign hash_here = level_is(fb, len_used, pos_reg, CHAR_HASH);
    assign plus_here = level_is(fb, len_used, pos_reg, CHAR_PLUS);
    assign plus_now  = plus_reg || plus_here;
    assign pos_cmp   = (!plus_reg && plus_here) ? (pos_reg + ONE) : pos_reg;

    // Step the filter pointer over one topic byte
    always_comb
    begin
        pos_next    = pos_reg;
        plus_next   = plus_reg;
        status_next = status_reg;
        if (status_reg == ST_MATCHING)
        begin
            if (!plus_reg && hash_here)
            begin
                status_next = ST_HASH;
            end
            else if (plus_now && (in_char_reg != CHAR_SLASH))
            begin
                pos_next  = pos_cmp;
                plus_next = 1'b1;
            end
            else
            begin
                plus_next = 1'b0;
                if (byte_is(fb, len_used, pos_cmp, in_char_reg))
                begin
                    pos_next = pos_cmp + ONE;
                end
                else
                begin
                    status_next = ST_FAILED;
                end
            end
        end
    end

    // Decide the result once the topic has ended
    always_comb
    begin
        case (status_next)
            ST_HASH:   verdict = 1'b1;
            ST_FAILED: verdict = 1'b0;
            ST_MATCHING:
            begin
                if (pos_next == len_used)
                begin
                    verdict = 1'b1;
                end
                else if (plus_next)
                begin
                    verdict = 1'b0;
                end
                else
                begin
                    // topic ended on an empty level
                    verdict = level_is(fb, len_used, pos_next, CHAR_HASH) ||
                              (level_is(fb, len_used, pos_next, CHAR_PLUS) &&
                               ((pos_next + ONE) == len_used));
                end
            end
            default:   verdict = 1'b0;
        endcase
    end

    // Hold the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (topic_valid && topic_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (topic_valid && topic_ready)
        begin
            in_char_reg <= topic_char;
            in_last_reg <= last_char;
        end
    end

    // Update the match state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            plus_reg   <= 1'b0;
            status_reg <= ST_MATCHING;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                pos_reg    <= '0;
                plus_reg   <= 1'b0;
                status_reg <= ST_MATCHING;
            end
            else
            begin
                pos_reg    <= pos_next;
                plus_reg   <= plus_next;
                status_reg <= status_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            matched_reg <= verdict;
        end
    end

    assign result_valid = out_valid_reg;
    assign matched      = matched_reg;

endmodule

@@ hw/rtl/topic_filter_match.sv @@
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+---------------------------
// topic    | in        | topic_valid / topic_ready  | topic_char, last_char
// result   | out       | result_valid / result_ready| matched
// config   | in        | psel, penable, pwrite      | paddr, pwdata (64 bit)
//
// One topic byte is taken every cycle; the filter pointer steps once per byte
// in a combinational update between the input register and the result register.
// The result is registered once its last byte leaves the input register.
// A byte that ends a topic waits in the input register while an earlier result
// is still held; other bytes keep flowing.
// Reset (rst_n low, asynchronous) loads the filter "#" and clears match state.
module topic_filter_match
    import tfm_pkg::*;
#(
    parameter int MAX_FILTER_BYTES = MAX_FILTER_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        topic_char,
    input  logic              last_char,
    input  logic              topic_valid,
    output logic              topic_ready,
    output logic              matched,
    output logic              result_valid,
    input  logic              result_ready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    filter_t filter;

    tfm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .filter  (filter)
    );

    tfm_match #(
        .MAX_FILTER_BYTES (MAX_FILTER_BYTES)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .filter       (filter),
        .topic_char   (topic_char),
        .last_char    (last_char),
        .topic_valid  (topic_valid),
        .topic_ready  (topic_ready),
        .matched      (matched),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

@@ hw/rtl/tfm_checker.sv @@
`include "topic_filter_match_macros.svh"

module tfm_checker (
    input logic clk,
    input logic rst_n,
    input logic topic_valid,
    input logic topic_ready,
    input logic last_char,
    input logic result_valid,
    input logic result_ready,
    input logic matched
);

    logic       last_acc;
    logic       res_acc;
    logic [1:0] open_reg;

    assign last_acc = topic_valid && topic_ready && last_char;
    assign res_acc  = result_valid && result_ready;

    // Count topics ended but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 2'd0;
        end
        else if (last_acc && !res_acc)
        begin
            open_reg <= open_reg + 2'd1;
        end
        else if (res_acc && !last_acc)
        begin
            open_reg <= open_reg - 2'd1;
        end
    end

    `TFM_ASSERT(a_result_has_topic, result_valid |-> (open_reg != 2'd0), "result without a topic")
    `TFM_ASSERT(a_open_bounded, open_reg != 2'd3, "too many topics in flight")
    `TFM_ASSERT(a_ready_when_empty, !result_valid |-> topic_ready, "input stalled with no result")
    `TFM_ASSERT_HOLD(a_matched_hold, result_valid && !result_ready, matched, "result changed")

endmodule

bind topic_filter_match tfm_checker u_tfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .topic_valid  (topic_valid),
    .topic_ready  (topic_ready),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .matched      (matched)
);

@@ tb/sv/topic_match_checker.sv @@
module topic_match_checker
    import tfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        topic_char,
    input  logic              last_char,
    input  logic              topic_valid,
    input  logic              topic_ready,
    input  logic              matched,
    input  logic              result_valid,
    input  logic              result_ready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    // Shadow copy of the filter registers
    logic [DATA_W-1:0] filter_words [FILTER_WORDS];
    logic [LEN_W-1:0]  filter_len;

    // Per-topic match state
    logic [LEN_W-1:0] pos;
    bit               in_plus;
    status_t          status;

    bit verdict_q [$];
    int mismatches;

    function automatic int used_bytes();
        return (filter_len > MAX_FILTER_BYTES_DEF) ? MAX_FILTER_BYTES_DEF : int'(filter_len);
    endfunction

    // Out-of-range positions give a value no byte can equal
    function automatic logic [8:0] filter_byte(int i);
        if (i < 0 || i >= used_bytes() || i >= MAX_FILTER_BYTES_DEF)
            return 9'h100;
        return {1'b0, filter_words[i / 8][8 * (i % 8) +: 8]};
    endfunction

    function automatic bit level_start(int p);
        return p == 0 || filter_byte(p - 1) == {1'b0, CHAR_SLASH};
    endfunction

    // True if the filter level at p consists of the single byte ch
    function automatic bit level_is_only(int p, logic [7:0] ch);
        int len;
        len = used_bytes();
        if (p >= len || !level_start(p) || filter_byte(p) != {1'b0, ch})
            return 1'b0;
        return (p + 1 >= len) || filter_byte(p + 1) == {1'b0, CHAR_SLASH};
    endfunction

    function automatic void step_topic(logic [7:0] c);
        int len;
        len = used_bytes();
        if (status != ST_MATCHING)
            return;
        if (!in_plus)
        begin
            if (level_is_only(int'(pos), CHAR_HASH))
            begin
                status = ST_HASH;
                return;
            end
            if (level_is_only(int'(pos), CHAR_PLUS))
            begin
                in_plus = 1'b1;
                pos = pos + 1'b1;
            end
        end
        // Inside a plus level only a slash ends the level
        if (in_plus)
        begin
            if (c != CHAR_SLASH)
                return;
            in_plus = 1'b0;
        end
        if (int'(pos) < len && filter_byte(int'(pos)) == {1'b0, c})
            pos = pos + 1'b1;
        else
            status = ST_FAILED;
    endfunction

    function automatic bit topic_verdict();
        int len;
        len = used_bytes();
        if (status == ST_HASH)
            return 1'b1;
        if (status != ST_MATCHING)
            return 1'b0;
        if (int'(pos) == len)
            return 1'b1;
        if (in_plus)
            return 1'b0;
        // Topic ended on an empty level
        if (level_is_only(int'(pos), CHAR_HASH))
            return 1'b1;
        if (level_is_only(int'(pos), CHAR_PLUS) && int'(pos) + 1 == len)
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic void clear_topic();
        pos = '0;
        in_plus = 1'b0;
        status = ST_MATCHING;
    endfunction

    // Queue a prediction behind the older ones
    function automatic void queue_verdict(bit v);
        verdict_q = {verdict_q, v};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_words[0] = FILTER_0_RESET;
            for (int i = 1; i < FILTER_WORDS; i++)
                filter_words[i] = '0;
            filter_len = LENGTH_RESET;
            clear_topic();
            verdict_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // Compare an accepted result word with the oldest prediction
            if (result_valid && result_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("matched: no result expected, actual %0b", matched);
                    mismatches++;
                end
                else if (matched !== verdict_q[0])
                begin
                    $error("matched: expected %0b, actual %0b", verdict_q[0], matched);
                    mismatches++;
                    void'(verdict_q.pop_front());
                end
                else
                    void'(verdict_q.pop_front());
            end

            // Advance the prediction on an accepted topic word
            if (topic_valid && topic_ready)
            begin
                step_topic(topic_char);
                if (last_char)
                begin
                    queue_verdict(topic_verdict());
                    clear_topic();
                end
            end

            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_FILTER_0, REG_FILTER_1, REG_FILTER_2, REG_FILTER_3:
                        filter_words[paddr[4:3]] = pwdata;
                    REG_LENGTH:
                        filter_len = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end

            fail_count <= mismatches;
            pending <= verdict_q.size();
        end
    end

endmodule

@@ tb/sv/topic_filter_match_tb.sv @@
module topic_filter_match_tb;
    import tfm_pkg::*;

    localparam int TARGET_WORDS = 1050;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic              clk;
    logic              rst_n;
    logic [7:0]        topic_char;
    logic              last_char;
    logic              topic_valid;
    logic              topic_ready;
    logic              matched;
    logic              result_valid;
    logic              result_ready;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int cycles;
    int words_sent;
    bit no_gaps;
    bit hold_results;

    // Filter image and topic under construction
    logic [7:0] filt [MAX_FILTER_BYTES_DEF];
    int         filt_used;
    logic [7:0] topic_q [$];

    topic_filter_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .topic_char   (topic_char),
        .last_char    (last_char),
        .topic_valid  (topic_valid),
        .topic_ready  (topic_ready),
        .matched      (matched),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    topic_match_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .topic_char   (topic_char),
        .last_char    (last_char),
        .topic_valid  (topic_valid),
        .topic_ready  (topic_ready),
        .matched      (matched),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("topic_filter_match verification failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid && !hold_results);
        end
    end

    // Add one byte at the end of the topic
    function automatic void append_char(logic [7:0] c);
        topic_q = {topic_q, c};
    endfunction

    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Pack the filter image and write every register
    task automatic program_filter(logic [LEN_W-1:0] len_reg);
        logic [DATA_W-1:0] w;
        for (int i = 0; i < FILTER_WORDS; i++)
        begin
            for (int b = 0; b < 8; b++)
                w[8 * b +: 8] = filt[8 * i + b];
            apb_write(reg_idx_t'(i), w);
        end
        apb_write(REG_LENGTH, DATA_W'(len_reg));
        filt_used = (len_reg > MAX_FILTER_BYTES_DEF) ? MAX_FILTER_BYTES_DEF : int'(len_reg);
    endtask

    task automatic set_filter(string s, logic [LEN_W-1:0] len_reg);
        for (int i = 0; i < MAX_FILTER_BYTES_DEF; i++)
            filt[i] = (i < s.len()) ? s[i] : 8'h00;
        program_filter(len_reg);
    endtask

    // Hold until every prediction is consumed and the pipeline is empty
    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(logic [7:0] c, bit last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            topic_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        topic_char <= c;
        last_char <= last;
        topic_valid <= 1'b1;
        do @(posedge clk); while (!topic_ready);
        words_sent++;
    endtask

    task automatic send_topic();
        for (int i = 0; i < topic_q.size(); i++)
            send_word(topic_q[i], i == topic_q.size() - 1);
    endtask

    task automatic send_text(string s);
        topic_q.delete();
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
        send_topic();
    endtask

    // Random filter built from literal and wildcard levels
    task automatic make_filter();
        string alpha;
        int n;
        int levels;
        int kind;
        int sel;
        logic [LEN_W-1:0] len_reg;
        alpha = "ab+#";
        n = 0;
        levels = $urandom_range(1, 5);
        for (int k = 0; k < levels && n < MAX_FILTER_BYTES_DEF; k++)
        begin
            if (k > 0)
            begin
                filt[n] = CHAR_SLASH;
                n++;
            end
            kind = $urandom_range(0, 5);
            if (kind == 0 && n < MAX_FILTER_BYTES_DEF)
            begin
                filt[n] = CHAR_PLUS;
                n++;
            end
            else if (kind == 1 && n < MAX_FILTER_BYTES_DEF)
            begin
                filt[n] = CHAR_HASH;
                n++;
                if ($urandom_range(0, 1) == 0)
                    break;
            end
            else
            begin
                for (int j = $urandom_range(0, 4); j > 0 && n < MAX_FILTER_BYTES_DEF; j--)
                begin
                    filt[n] = alpha[$urandom_range(0, 3)];
                    n++;
                end
            end
        end
        // Fill unused bytes at random
        for (int i = n; i < MAX_FILTER_BYTES_DEF; i++)
            filt[i] = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 11);
        if (sel == 0)
            len_reg = '0;
        else if (sel == 1)
            len_reg = LEN_W'($urandom_range(MAX_FILTER_BYTES_DEF + 1, 63));
        else if (sel == 2)
            len_reg = LEN_W'(MAX_FILTER_BYTES_DEF);
        else
            len_reg = LEN_W'(n);
        program_filter(len_reg);
    endtask

    // Topic shaped after the filter, sometimes damaged
    task automatic make_topic();
        string alpha;
        string tail;
        int lvl;
        int kind;
        int idx;
        alpha = "ab+#";
        tail = "ab/+#";
        topic_q.delete();
        lvl = 0;
        for (int p = 0; p <= filt_used; p++)
        begin
            if (p == filt_used || filt[p] == CHAR_SLASH)
            begin
                if (p - lvl == 1 && filt[lvl] == CHAR_PLUS)
                begin
                    for (int j = $urandom_range(0, 3); j > 0; j--)
                        append_char(alpha[$urandom_range(0, 3)]);
                end
                else if (p - lvl == 1 && filt[lvl] == CHAR_HASH)
                begin
                    if ($urandom_range(0, 2) == 0 && topic_q.size() > 0)
                        void'(topic_q.pop_back());
                    else
                        for (int j = $urandom_range(0, 6); j > 0; j--)
                            append_char(tail[$urandom_range(0, 4)]);
                    break;
                end
                else
                begin
                    for (int j = lvl; j < p; j++)
                        append_char(filt[j]);
                end
                if (p < filt_used)
                    append_char(CHAR_SLASH);
                lvl = p + 1;
            end
        end
        if (topic_q.size() == 0)
            append_char("a");
        if ($urandom_range(0, 3) == 0)
        begin
            kind = $urandom_range(0, 2);
            idx = $urandom_range(0, topic_q.size() - 1);
            if (kind == 0)
                topic_q[idx] = alpha[$urandom_range(0, 3)];
            else if (kind == 1 && topic_q.size() > 1)
                void'(topic_q.pop_back());
            else
            begin
                append_char(CHAR_SLASH);
                append_char("a");
            end
        end
        while (topic_q.size() > 48)
            void'(topic_q.pop_back());
    endtask

    task automatic make_noise(int max_len);
        topic_q.delete();
        for (int j = $urandom_range(1, max_len); j > 0; j--)
            append_char(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        bit holding;
        clk = 1'b0;
        rst_n = 1'b0;
        topic_char = '0;
        last_char = 1'b0;
        topic_valid = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        words_sent = 0;
        no_gaps = 1'b0;
        hold_results = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset filter is a lone hash: everything matches
        send_word("a", 1'b1);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);

        // Plus level, including an empty one
        topic_valid <= 1'b0;
        wait_idle();
        set_filter("a/+", 6'd3);
        send_text("a/b");
        send_text("a/");
        send_text("a");

        // Hash level does not match its parent level
        topic_valid <= 1'b0;
        wait_idle();
        set_filter("a/#", 6'd3);
        send_text("a");
        send_text("a/x/y");

        // Empty filter matches nothing
        topic_valid <= 1'b0;
        wait_idle();
        set_filter("", 6'd0);
        send_text("a");

        // Wildcard sharing its level compares literally
        topic_valid <= 1'b0;
        wait_idle();
        set_filter("a+/b", 6'd4);
        send_text("a+/b");

        // Shrink the filter in the middle of a topic
        topic_valid <= 1'b0;
        wait_idle();
        set_filter("ab", 6'd2);
        send_word("a", 1'b0);
        topic_valid <= 1'b0;
        wait_idle();
        apb_write(REG_LENGTH, 64'd1);
        send_word("b", 1'b1);

        // All-ones filter with an oversized length
        topic_valid <= 1'b0;
        wait_idle();
        for (int i = 0; i < MAX_FILTER_BYTES_DEF; i++)
            filt[i] = 8'hFF;
        program_filter(6'd63);
        send_word(8'hFF, 1'b1);

        // Random phases, each with its own filter
        for (int phase = 0; words_sent < TARGET_WORDS; phase++)
        begin
            topic_valid <= 1'b0;
            wait_idle();
            make_filter();
            no_gaps = ($urandom_range(0, 3) == 0);
            holding = (phase == 1) || ($urandom_range(0, 9) == 0);
            if (holding)
                hold_results = 1'b1;
            repeat ($urandom_range(4, 12))
            begin
                if (holding)
                    make_noise(3);
                else if ($urandom_range(0, 7) == 0)
                    make_noise(6);
                else
                    make_topic();
                send_topic();
            end
        end

        topic_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("topic_filter_match verification clean");
        else
            $display("topic_filter_match verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tfm_pkg.sv
hw/rtl/tfm_cfg_regs.sv
hw/rtl/tfm_match.sv
hw/rtl/topic_filter_match.sv
hw/rtl/tfm_checker.sv
tb/sv/topic_match_checker.sv
tb/sv/topic_filter_match_tb.sv
